[rtl/frc8_pkg.sv]
// Shared types, constants and the CRC-8 step function for the frame receiver.
package frc8_pkg;

  localparam logic [7:0] SYNC_BYTE = 8'hAA;
  localparam logic [7:0] CRC_POLY  = 8'h8C;

  // Configuration register byte addresses.
  localparam logic [1:0] ADDR_MAX_PAYLOAD = 2'd0;

  typedef enum logic [1:0] {
    PH_HUNT    = 2'd0,
    PH_HEADER  = 2'd1,
    PH_PAYLOAD = 2'd2,
    PH_CRC     = 2'd3
  } phase_t;

  typedef enum logic [2:0] {
    EV_PAYLOAD  = 3'd0,
    EV_GOOD     = 3'd1,
    EV_CRC_BAD  = 3'd2,
    EV_TOO_LONG = 3'd3,
    EV_LINE_ERR = 3'd4
  } event_t;

  typedef struct packed {
    event_t     event_res;
    logic [7:0] src_addr;
    logic [7:0] dst_addr;
    logic [7:0] command;
    logic [7:0] length;
    logic [7:0] payload_byte;
    logic [7:0] payload_index;
  } res_t;

  // One byte of the reflected Dallas/Maxim CRC-8, LSB first.
  function automatic logic [7:0] crc8_maxim(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] v;
    v = crc ^ b;
    for (int k = 0; k < 8; k++) begin
      v = v[0] ? ((v >> 1) ^ CRC_POLY) : (v >> 1);
    end
    return v;
  endfunction

  localparam logic [7:0] CRC_AFTER_SYNC = crc8_maxim(8'h00, SYNC_BYTE);

endpackage

[rtl/frc8_core.sv]
// Frame parsing state machine: sync hunt, header, payload and CRC check.
module frc8_core (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              step,
  input  logic [7:0]        rx_byte,
  input  logic              rx_error,
  input  logic [7:0]        max_payload,
  output logic              res_valid,
  output frc8_pkg::res_t    res
);

  frc8_pkg::phase_t phase_r, phase_nxt;
  logic [1:0] hdr_cnt_r, hdr_cnt_nxt;
  logic [7:0] src_r, src_nxt;
  logic [7:0] dst_r, dst_nxt;
  logic [7:0] cmd_r, cmd_nxt;
  logic [7:0] len_r, len_nxt;
  logic [7:0] pay_cnt_r, pay_cnt_nxt;
  logic [7:0] crc_r, crc_nxt;

  logic [7:0] crc_step;
  logic [7:0] src_cap, dst_cap, cmd_cap, len_cap;
  logic [7:0] pay_cnt_inc;
  logic       is_sync, hdr_last, too_long;

  // Header fields as they stand once this byte is captured.
  always_comb begin
    crc_step    = frc8_pkg::crc8_maxim(crc_r, rx_byte);
    is_sync     = (rx_byte == frc8_pkg::SYNC_BYTE);
    pay_cnt_inc = pay_cnt_r + 8'd1;
    src_cap     = src_r;
    dst_cap     = dst_r;
    cmd_cap     = cmd_r;
    len_cap     = len_r;
    if (phase_r == frc8_pkg::PH_HEADER) begin
      case (hdr_cnt_r)
        2'd0:    src_cap = rx_byte;
        2'd1:    dst_cap = rx_byte;
        2'd2:    cmd_cap = rx_byte;
        default: len_cap = rx_byte;
      endcase
    end
    hdr_last = (phase_r == frc8_pkg::PH_HEADER) && (hdr_cnt_r == 2'd3);
    too_long = hdr_last && (len_cap > max_payload);
  end

  // Next state.
  always_comb begin
    logic restart;
    logic hunt;
    restart     = 1'b0;
    hunt        = 1'b0;
    phase_nxt   = phase_r;
    hdr_cnt_nxt = hdr_cnt_r;
    src_nxt     = src_cap;
    dst_nxt     = dst_cap;
    cmd_nxt     = cmd_cap;
    len_nxt     = len_cap;
    pay_cnt_nxt = pay_cnt_r;
    crc_nxt     = crc_r;
    if (rx_error) begin
      hunt = 1'b1;
    end else begin
      case (phase_r)
        frc8_pkg::PH_HEADER: begin
          crc_nxt = crc_step;
          if (!hdr_last) begin
            hdr_cnt_nxt = hdr_cnt_r + 2'd1;
          end else if (too_long) begin
            restart = is_sync;
            hunt    = !is_sync;
          end else begin
            hdr_cnt_nxt = 2'd0;
            pay_cnt_nxt = 8'd0;
            phase_nxt   = (len_cap == 8'd0) ? frc8_pkg::PH_CRC : frc8_pkg::PH_PAYLOAD;
          end
        end
        frc8_pkg::PH_PAYLOAD: begin
          crc_nxt     = crc_step;
          pay_cnt_nxt = pay_cnt_inc;
          if (pay_cnt_inc >= len_r) begin
            phase_nxt = frc8_pkg::PH_CRC;
          end
        end
        frc8_pkg::PH_CRC: begin
          restart = (rx_byte != crc_r) && is_sync;
          hunt    = !restart;
        end
        default: begin
          restart = is_sync;
          hunt    = !is_sync;
        end
      endcase
    end
    if (restart || hunt) begin
      phase_nxt   = restart ? frc8_pkg::PH_HEADER : frc8_pkg::PH_HUNT;
      hdr_cnt_nxt = 2'd0;
      src_nxt     = 8'd0;
      dst_nxt     = 8'd0;
      cmd_nxt     = 8'd0;
      len_nxt     = 8'd0;
      pay_cnt_nxt = 8'd0;
      crc_nxt     = restart ? frc8_pkg::CRC_AFTER_SYNC : 8'd0;
    end
  end

  // Result for this byte.
  always_comb begin
    res_valid         = 1'b0;
    res.event_res     = frc8_pkg::EV_PAYLOAD;
    res.src_addr      = src_cap;
    res.dst_addr      = dst_cap;
    res.command       = cmd_cap;
    res.length        = len_cap;
    res.payload_byte  = 8'd0;
    res.payload_index = 8'd0;
    if (rx_error) begin
      res_valid     = 1'b1;
      res.event_res = frc8_pkg::EV_LINE_ERR;
      res.src_addr  = src_r;
      res.dst_addr  = dst_r;
      res.command   = cmd_r;
      res.length    = len_r;
    end else begin
      case (phase_r)
        frc8_pkg::PH_HEADER: begin
          res_valid     = too_long;
          res.event_res = frc8_pkg::EV_TOO_LONG;
        end
        frc8_pkg::PH_PAYLOAD: begin
          res_valid         = 1'b1;
          res.payload_byte  = rx_byte;
          res.payload_index = pay_cnt_r;
        end
        frc8_pkg::PH_CRC: begin
          res_valid     = 1'b1;
          res.event_res = (rx_byte == crc_r) ? frc8_pkg::EV_GOOD : frc8_pkg::EV_CRC_BAD;
        end
        default: begin
          res_valid = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= frc8_pkg::PH_HUNT;
      hdr_cnt_r <= 2'd0;
      src_r     <= 8'd0;
      dst_r     <= 8'd0;
      cmd_r     <= 8'd0;
      len_r     <= 8'd0;
      pay_cnt_r <= 8'd0;
      crc_r     <= 8'd0;
    end else if (step) begin
      phase_r   <= phase_nxt;
      hdr_cnt_r <= hdr_cnt_nxt;
      src_r     <= src_nxt;
      dst_r     <= dst_nxt;
      cmd_r     <= cmd_nxt;
      len_r     <= len_nxt;
      pay_cnt_r <= pay_cnt_nxt;
      crc_r     <= crc_nxt;
    end
  end

`ifndef SYNTHESIS
  a_err_hunts: assert property (@(posedge clk) disable iff (!rst_n)
    (step && rx_error) |=> (phase_r == frc8_pkg::PH_HUNT && len_r == 8'd0))
    else $error("line error did not return receiver to hunting");
  a_hdr_cnt_phase: assert property (@(posedge clk) disable iff (!rst_n)
    (hdr_cnt_r != 2'd0) |-> (phase_r == frc8_pkg::PH_HEADER))
    else $error("header count active outside header phase");
  a_pay_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == frc8_pkg::PH_PAYLOAD) |-> (pay_cnt_r < len_r))
    else $error("payload count ran past frame length");
`endif

endmodule

[rtl/frame_receiver_crc8.sv]
// Top level of the framed byte receiver with CRC-8 check.
//
// Usage:
//   Input channel (in_valid/in_ready): one received byte per item, or a line
//   error flag. The receiver hunts for sync byte 0xAA, collects source,
//   destination, command and length, passes payload bytes on, then checks the
//   trailing Dallas/Maxim CRC-8 (covering sync, header and payload).
//   Result channel (out_valid/out_ready): zero or one item per input item:
//   a payload byte with its index, or a frame status (good, CRC bad, too
//   long, line error) together with the frame header as held.
//   Configuration: APB write of max_payload at address 0; longer frames drop.
// Timing:
//   A result goes to the output register, or to the skid register while the
//   output register is held. Throughput is one item per cycle while in_ready is
//   high; the whole parse step is one pass of logic between the parser state
//   and the output register. A two-entry output buffer (output register plus
//   skid register) lets input continue for one more result while the result
//   channel stalls; in_ready drops only when both entries hold results.
// Reset: synchronous active-low rst_n; receiver returns to hunting, header
//   clears, max_payload goes to 255 and both output entries empty.
module frame_receiver_crc8 (
  input  logic        clk,
  input  logic        rst_n,
  // input channel
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_rx_byte,
  input  logic        in_rx_error,
  // result channel
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  out_event_res,
  output logic [7:0]  out_src_addr,
  output logic [7:0]  out_dst_addr,
  output logic [7:0]  out_command,
  output logic [7:0]  out_length,
  output logic [7:0]  out_payload_byte,
  output logic [7:0]  out_payload_index,
  // configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [1:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [7:0]     max_payload_r;
  logic           in_fire;
  logic           out_fire;
  logic           res_valid;
  frc8_pkg::res_t res;

  logic           out_valid_r;
  frc8_pkg::res_t out_r;
  logic           skid_valid_r;
  frc8_pkg::res_t skid_r;

  // Configuration register: zero wait states.
  assign pready = 1'b1;
  assign prdata = (paddr == frc8_pkg::ADDR_MAX_PAYLOAD) ? {24'd0, max_payload_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_payload_r <= 8'hFF;
    end else if (psel && penable && pwrite && pready &&
                 paddr == frc8_pkg::ADDR_MAX_PAYLOAD) begin
      max_payload_r <= pwdata[7:0];
    end
  end

  // Take an item whenever the skid entry is free.
  assign in_ready = !skid_valid_r;
  assign in_fire  = in_valid && in_ready;
  assign out_fire = out_valid_r && out_ready;

  frc8_core u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .step        (in_fire),
    .rx_byte     (in_rx_byte),
    .rx_error    (in_rx_error),
    .max_payload (max_payload_r),
    .res_valid   (res_valid),
    .res         (res)
  );

  // Output register plus skid entry. The skid fills only when a new result
  // lands while the output register is held.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (skid_valid_r) begin
      if (out_fire) begin
        skid_valid_r <= 1'b0;
      end
    end else if (in_fire && res_valid) begin
      if (!out_valid_r || out_fire) begin
        out_valid_r <= 1'b1;
      end else begin
        skid_valid_r <= 1'b1;
      end
    end else if (out_fire) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid_r) begin
      if (out_fire) begin
        out_r <= skid_r;
      end
    end else if (in_fire && res_valid) begin
      if (!out_valid_r || out_fire) begin
        out_r <= res;
      end else begin
        skid_r <= res;
      end
    end
  end

  assign out_valid         = out_valid_r;
  assign out_event_res     = out_r.event_res;
  assign out_src_addr      = out_r.src_addr;
  assign out_dst_addr      = out_r.dst_addr;
  assign out_command       = out_r.command;
  assign out_length        = out_r.length;
  assign out_payload_byte  = out_r.payload_byte;
  assign out_payload_index = out_r.payload_index;

`ifndef SYNTHESIS
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid entry holds a result while output register is empty");
  a_skid_fills: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && res_valid && out_valid_r && !out_ready) |=> skid_valid_r)
    else $error("result during stall was not kept in skid entry");
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> (!out_valid_r && !skid_valid_r))
    else $error("output buffer not empty after reset");
`endif

endmodule

[sim/frc8_event_checker.sv]
`timescale 1ns / 1ps
// Frame receiver checker: follows the byte stream, predicts each result item and compares.
module frc8_event_checker #(
  parameter logic [1:0] MAX_PAYLOAD_ADDR = '0
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [7:0]  in_rx_byte,
  input  logic        in_rx_error,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [2:0]  out_event_res,
  input  logic [7:0]  out_src_addr,
  input  logic [7:0]  out_dst_addr,
  input  logic [7:0]  out_command,
  input  logic [7:0]  out_length,
  input  logic [7:0]  out_payload_byte,
  input  logic [7:0]  out_payload_index,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic        pready,
  input  logic [1:0]  paddr,
  input  logic [31:0] pwdata,
  output int          mismatch_count,
  output int          pending_count
);

  frc8_pkg::phase_t rx_phase;
  logic [1:0]       hdr_idx;
  logic [7:0]       src_q, dst_q, cmd_q, len_q;
  logic [7:0]       pay_idx;
  logic [7:0]       crc_q;
  logic [7:0]       max_len;
  frc8_pkg::res_t   expected_events[$];
  int               fail_total = 0;

  // Bit-serial form of the reflected CRC-8, LSB first.
  function automatic logic [7:0] crc_step(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc;
    for (int i = 0; i < 8; i++) begin
      if (c[0] ^ b[i]) c = (c >> 1) ^ frc8_pkg::CRC_POLY;
      else c = c >> 1;
    end
    return c;
  endfunction

  function automatic string describe(input frc8_pkg::res_t r);
    return $sformatf("event %0d src %h dst %h cmd %h len %h byte %h idx %h",
                     r.event_res, r.src_addr, r.dst_addr, r.command, r.length,
                     r.payload_byte, r.payload_index);
  endfunction

  task automatic clear_frame();
    rx_phase = frc8_pkg::PH_HUNT;
    hdr_idx  = '0;
    src_q    = '0;
    dst_q    = '0;
    cmd_q    = '0;
    len_q    = '0;
    pay_idx  = '0;
    crc_q    = '0;
  endtask

  // Sync byte seen: start a frame with the sync byte already in the CRC.
  task automatic open_frame();
    clear_frame();
    rx_phase = frc8_pkg::PH_HEADER;
    crc_q    = crc_step(8'h00, frc8_pkg::SYNC_BYTE);
  endtask

  task automatic post(input frc8_pkg::event_t ev, input logic [7:0] pb,
                      input logic [7:0] pi);
    frc8_pkg::res_t r;
    r.event_res     = ev;
    r.src_addr      = src_q;
    r.dst_addr      = dst_q;
    r.command       = cmd_q;
    r.length        = len_q;
    r.payload_byte  = pb;
    r.payload_index = pi;
    expected_events.push_back(r);
  endtask

  task automatic track_rx_byte(input logic [7:0] b, input logic err);
    if (err) begin
      post(frc8_pkg::EV_LINE_ERR, 8'h00, 8'h00);
      clear_frame();
    end else begin
      case (rx_phase)
        frc8_pkg::PH_HEADER: begin
          crc_q = crc_step(crc_q, b);
          case (hdr_idx)
            2'd0:    src_q = b;
            2'd1:    dst_q = b;
            2'd2:    cmd_q = b;
            default: len_q = b;
          endcase
          if (hdr_idx != 2'd3) begin
            hdr_idx = hdr_idx + 2'd1;
          end else begin
            hdr_idx = '0;
            if (len_q > max_len) begin
              post(frc8_pkg::EV_TOO_LONG, 8'h00, 8'h00);
              if (b == frc8_pkg::SYNC_BYTE) open_frame();
              else clear_frame();
            end else begin
              pay_idx  = '0;
              rx_phase = (len_q == 8'd0) ? frc8_pkg::PH_CRC : frc8_pkg::PH_PAYLOAD;
            end
          end
        end
        frc8_pkg::PH_PAYLOAD: begin
          crc_q = crc_step(crc_q, b);
          post(frc8_pkg::EV_PAYLOAD, b, pay_idx);
          pay_idx = pay_idx + 8'd1;
          if (pay_idx >= len_q) rx_phase = frc8_pkg::PH_CRC;
        end
        frc8_pkg::PH_CRC: begin
          if (b == crc_q) begin
            post(frc8_pkg::EV_GOOD, 8'h00, 8'h00);
            clear_frame();
          end else begin
            post(frc8_pkg::EV_CRC_BAD, 8'h00, 8'h00);
            if (b == frc8_pkg::SYNC_BYTE) open_frame();
            else clear_frame();
          end
        end
        default: begin
          if (b == frc8_pkg::SYNC_BYTE) open_frame();
          else clear_frame();
        end
      endcase
    end
  endtask

  task automatic compare_result();
    frc8_pkg::res_t got;
    frc8_pkg::res_t want;
    got.event_res     = frc8_pkg::event_t'(out_event_res);
    got.src_addr      = out_src_addr;
    got.dst_addr      = out_dst_addr;
    got.command       = out_command;
    got.length        = out_length;
    got.payload_byte  = out_payload_byte;
    got.payload_index = out_payload_index;
    if (expected_events.size() == 0) begin
      if (fail_total < 10) $display("unexpected result item: %s", describe(got));
      fail_total++;
    end else begin
      want = expected_events.pop_front();
      if (got.event_res !== want.event_res || got.src_addr !== want.src_addr ||
          got.dst_addr !== want.dst_addr || got.command !== want.command ||
          got.length !== want.length || got.payload_byte !== want.payload_byte ||
          got.payload_index !== want.payload_index) begin
        if (fail_total < 10) begin
          $display("result mismatch: expected %s", describe(want));
          $display("                 actual   %s", describe(got));
        end
        fail_total++;
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      clear_frame();
      max_len = 8'hFF;
      expected_events.delete();
    end else begin
      if (psel && penable && pwrite && pready && paddr == MAX_PAYLOAD_ADDR)
        max_len = pwdata[7:0];
      // Compare before predicting so a result can never match an item from the same edge.
      if (out_valid && out_ready) compare_result();
      if (in_valid && in_ready) track_rx_byte(in_rx_byte, in_rx_error);
    end
    mismatch_count <= fail_total;
    pending_count  <= expected_events.size();
  end

endmodule

[sim/tb_frame_receiver_crc8.sv]
`timescale 1ns / 1ps
// Testbench top for the frame receiver: drives bytes, config writes and back-pressure.
module tb_frame_receiver_crc8;

  localparam int         STIM_ITEMS       = 1900;
  localparam int         NUM_PHASES       = 6;

  // How a frame ends: good CRC, good CRC that happens to equal the sync byte,
  // corrupted CRC, or a corrupted CRC forced to the sync byte (restart).
  typedef enum int {TAIL_GOOD, TAIL_GOOD_SYNC, TAIL_BAD, TAIL_BAD_SYNC} tail_t;

  logic        clk;
  logic        rst_n             = 1'b0;
  logic        in_valid          = 1'b0;
  logic        in_ready;
  logic [7:0]  in_rx_byte        = 8'h00;
  logic        in_rx_error       = 1'b0;
  logic        out_valid;
  logic        out_ready         = 1'b0;
  logic [2:0]  out_event_res;
  logic [7:0]  out_src_addr;
  logic [7:0]  out_dst_addr;
  logic [7:0]  out_command;
  logic [7:0]  out_length;
  logic [7:0]  out_payload_byte;
  logic [7:0]  out_payload_index;
  logic        psel              = 1'b0;
  logic        penable           = 1'b0;
  logic        pwrite            = 1'b0;
  logic [1:0]  paddr             = '0;
  logic [31:0] pwdata            = '0;
  logic [31:0] prdata;
  logic        pready;

  int          mismatch_count;
  int          pending_count;
  int          frame_items       = 0;
  logic [7:0]  cur_max           = 8'hFF;
  // idling steers the input gaps; idle_on is its copy for the result-side stall process.
  bit          idling            = 1'b0;
  bit          idle_on           = 1'b0;
  int          stall_left        = 0;

  frame_receiver_crc8 dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_rx_byte       (in_rx_byte),
    .in_rx_error      (in_rx_error),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_event_res    (out_event_res),
    .out_src_addr     (out_src_addr),
    .out_dst_addr     (out_dst_addr),
    .out_command      (out_command),
    .out_length       (out_length),
    .out_payload_byte (out_payload_byte),
    .out_payload_index(out_payload_index),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready)
  );

  frc8_event_checker #(.MAX_PAYLOAD_ADDR(frc8_pkg::ADDR_MAX_PAYLOAD)) u_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_rx_byte       (in_rx_byte),
    .in_rx_error      (in_rx_error),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_event_res    (out_event_res),
    .out_src_addr     (out_src_addr),
    .out_dst_addr     (out_dst_addr),
    .out_command      (out_command),
    .out_length       (out_length),
    .out_payload_byte (out_payload_byte),
    .out_payload_index(out_payload_index),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .pready           (pready),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .mismatch_count   (mismatch_count),
    .pending_count    (pending_count)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Hard stop far beyond the slowest legal run.
  initial begin
    #20_000_000;
    $display("*** FAILED ***");
    $finish;
  end

  // Result-side back-pressure: drop ready in bursts of random length while idling is on.
  always @(posedge clk) begin
    if (stall_left > 0) begin
      out_ready  <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (idle_on && $urandom_range(0, 4) == 0) begin
      out_ready  <= 1'b0;
      stall_left <= $urandom_range(0, 6);
    end else begin
      out_ready <= 1'b1;
    end
  end

  task automatic set_idling(input bit on);
    idling = on;
    idle_on <= on;
  endtask

  // Offer one item, with an optional gap first, and hold it until accepted.
  task automatic send_rx(input logic [7:0] b, input logic err);
    if (idling && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
    in_valid    <= 1'b1;
    in_rx_byte  <= b;
    in_rx_error <= err;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // Drop the input, wait for every expected result, then let the pipe settle.
  task automatic wait_idle(input int settle);
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (settle) @(posedge clk);
  endtask

  // APB write: setup cycle, then access cycle held until pready.
  task automatic write_max_payload(input logic [7:0] v);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= frc8_pkg::ADDR_MAX_PAYLOAD;
    pwdata  <= {24'($urandom), v};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    cur_max = v;
  endtask

  // Build and send one frame. A line error replaces the byte at err_at, if that
  // index lies inside the frame. with_sync is cleared when the receiver already
  // restarted on the last byte of a failed frame. restarted reports whether this
  // frame's last byte does the same.
  task automatic send_frame(input logic [7:0] src, input logic [7:0] dst,
                            input logic [7:0] cmd, input logic [7:0] len,
                            input tail_t tail, input int err_at, input bit with_sync,
                            output bit restarted);
    logic [7:0] frame_bytes[$];
    logic [7:0] crc;
    logic [7:0] tail_byte;
    bit         restart_next;
    restart_next = 1'b0;
    if (with_sync) frame_bytes.push_back(frc8_pkg::SYNC_BYTE);
    frame_bytes.push_back(src);
    frame_bytes.push_back(dst);
    frame_bytes.push_back(cmd);
    frame_bytes.push_back(len);
    if (len > cur_max) begin
      // Frame drops right after the length byte.
      restart_next = (len == frc8_pkg::SYNC_BYTE);
    end else begin
      for (int i = 0; i < int'(len); i++) frame_bytes.push_back(8'($urandom));
      crc = frc8_pkg::crc8_maxim(8'h00, frc8_pkg::SYNC_BYTE);
      for (int i = int'(with_sync); i < frame_bytes.size() - 1; i++)
        crc = frc8_pkg::crc8_maxim(crc, frame_bytes[i]);
      // Pick the last payload byte so that the CRC lands on the sync byte.
      if (tail == TAIL_GOOD_SYNC && len != 8'd0) begin
        for (int v = 0; v < 256; v++)
          if (frc8_pkg::crc8_maxim(crc, v[7:0]) == frc8_pkg::SYNC_BYTE)
            frame_bytes[frame_bytes.size() - 1] = v[7:0];
      end
      crc = frc8_pkg::crc8_maxim(crc, frame_bytes[frame_bytes.size() - 1]);
      case (tail)
        TAIL_BAD: begin
          tail_byte    = crc ^ 8'($urandom_range(1, 255));
          restart_next = (tail_byte == frc8_pkg::SYNC_BYTE);
        end
        TAIL_BAD_SYNC: begin
          tail_byte    = (crc != frc8_pkg::SYNC_BYTE) ? frc8_pkg::SYNC_BYTE : (crc ^ 8'h01);
          restart_next = (tail_byte == frc8_pkg::SYNC_BYTE);
        end
        default: tail_byte = crc;
      endcase
      frame_bytes.push_back(tail_byte);
    end
    foreach (frame_bytes[i]) begin
      frame_items++;
      if (i == err_at) begin
        send_rx(8'($urandom), 1'b1);
        restart_next = 1'b0;
        break;
      end
      send_rx(frame_bytes[i], 1'b0);
    end
    restarted = restart_next;
  endtask

  // Random traffic: mostly well-formed frames with random content, plus
  // line noise, lone line errors, oversize lengths and corrupted tails.
  task automatic run_frames(input int n_items, input bit allow_idle);
    int         target;
    int         pick;
    int         err_at;
    bit         restarted;
    logic [7:0] len;
    logic [7:0] noise;
    tail_t      tail;
    target    = frame_items + n_items;
    restarted = 1'b0;
    if (!allow_idle) set_idling(1'b0);
    while (frame_items < target) begin
      if (allow_idle && $urandom_range(0, 5) == 0) set_idling(!idling);
      if (!restarted && $urandom_range(0, 3) == 0) begin
        repeat ($urandom_range(1, 3)) begin
          do noise = 8'($urandom); while (noise == frc8_pkg::SYNC_BYTE);
          frame_items++;
          send_rx(noise, 1'b0);
        end
      end
      if (!restarted && $urandom_range(0, 29) == 0) begin
        frame_items++;
        send_rx(8'($urandom), 1'b1);
      end
      pick = $urandom_range(0, 99);
      if (pick < 76) len = 8'($urandom_range(0, 8));
      else if (pick < 84) len = (cur_max == 8'hFF) ? 8'($urandom_range(9, 20)) : cur_max + 8'd1;
      else if (pick < 88) len = frc8_pkg::SYNC_BYTE;
      else if (pick < 89) len = 8'($urandom_range(200, 255));
      else len = 8'($urandom_range(9, 40));
      pick = $urandom_range(0, 9);
      if (pick < 6) tail = TAIL_GOOD;
      else if (pick == 6) tail = TAIL_GOOD_SYNC;
      else if (pick < 9) tail = TAIL_BAD;
      else tail = TAIL_BAD_SYNC;
      err_at = ($urandom_range(0, 11) == 0) ? $urandom_range(0, 5 + int'(len)) : -1;
      send_frame(8'($urandom), 8'($urandom), 8'($urandom), len, tail, err_at,
                 !restarted, restarted);
    end
  endtask

  initial begin : stimulus
    bit         r;
    logic [7:0] phase_max[NUM_PHASES];
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    set_idling(1'b1);

    // Directed: noise and a line error while hunting.
    send_rx(8'h00, 1'b0);
    send_rx(8'hFF, 1'b0);
    send_rx(8'h5A, 1'b1);
    // Empty payload goes straight to the CRC byte.
    send_frame(8'h00, 8'hFF, 8'h00, 8'd0, TAIL_GOOD, -1, 1'b1, r);
    // Good frame whose CRC equals the sync byte: consume it, back to hunting.
    send_frame(8'hFF, 8'h00, 8'hFF, 8'd2, TAIL_GOOD_SYNC, -1, 1'b1, r);
    // Bad CRC that is the sync byte restarts; next frame has no sync of its own.
    send_frame(8'h12, 8'h34, 8'h56, 8'd1, TAIL_BAD_SYNC, -1, 1'b1, r);
    send_frame(8'h01, 8'h80, 8'h7F, 8'd1, TAIL_BAD, -1, !r, r);
    // Line error in the middle of the payload.
    send_frame(8'hA5, 8'h5A, 8'hC3, 8'd3, TAIL_GOOD, 6, 1'b1, r);

    // Smallest limit: only empty frames pass, a sync-valued length restarts.
    wait_idle(4);
    write_max_payload(8'd0);
    send_frame(8'h3C, 8'hC3, 8'h01, 8'd0, TAIL_GOOD, -1, 1'b1, r);
    send_frame(8'h11, 8'h22, 8'h33, 8'd1, TAIL_GOOD, -1, 1'b1, r);
    send_frame(8'h44, 8'h55, 8'h66, frc8_pkg::SYNC_BYTE, TAIL_GOOD, -1, 1'b1, r);
    send_frame(8'h77, 8'h88, 8'h99, 8'd0, TAIL_GOOD, -1, !r, r);

    // Random phases over several limits, extremes included; the last runs without idling.
    phase_max = '{8'd255, 8'd3, 8'($urandom_range(1, 254)), 8'd0, 8'd200, 8'd255};
    for (int k = 0; k < NUM_PHASES; k++) begin
      wait_idle(4);
      write_max_payload(phase_max[k]);
      run_frames(STIM_ITEMS / NUM_PHASES, k < NUM_PHASES - 1);
    end

    wait_idle(10);
    if (mismatch_count == 0 && pending_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

[frame_receiver_crc8.f]
rtl/frc8_pkg.sv
rtl/frc8_core.sv
rtl/frame_receiver_crc8.sv
sim/frc8_event_checker.sv
sim/tb_frame_receiver_crc8.sv
